@@ rtl/core/wcr_pkg.sv @@
// shared constants, types and report characters for the line, word and byte counter
`default_nettype none
package wcr_pkg;

   localparam int COUNT_WIDTH = 32;
   // decimal digits needed for the largest count, log10(2) ~ 0.30103
   localparam int DIGITS      = (COUNT_WIDTH * 30103) / 100000 + 1;
   localparam int BCD_WIDTH   = DIGITS * 4;
   localparam int BIT_W       = $clog2(COUNT_WIDTH);
   localparam int DIG_W       = (DIGITS > 1) ? $clog2(DIGITS) : 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;

   localparam logic CMD_DATA = 1'b0;
   localparam logic CMD_END  = 1'b1;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] line_cnt;
      logic [COUNT_WIDTH-1:0] word_cnt;
      logic [COUNT_WIDTH-1:0] byte_cnt;
   } wcr_snap_type;

   typedef struct packed {
      logic         push;
      wcr_snap_type snap;
   } wcr_push_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_CONV,
      BK_GAP1,
      BK_GAP2,
      BK_DIGIT,
      BK_NL
   } bk_state_type;

endpackage
`default_nettype wire

@@ rtl/core/wcr_front.sv @@
// front end: takes requests, classifies bytes and keeps the running counts
`default_nettype none
module wcr_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [7:0]         req_tdata,
   input  wire logic [0:0]         req_tuser,
   input  wire logic               q_full,
   output wcr_pkg::wcr_push_type   push_out
);
   import wcr_pkg::*;

   logic [COUNT_WIDTH-1:0] line_ff, line_in;
   logic [COUNT_WIDTH-1:0] word_ff, word_in;
   logic [COUNT_WIDTH-1:0] byte_ff, byte_in;
   logic                   inword_ff, inword_in;
   logic                   accept;
   logic                   blank;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign blank      = (req_tdata == CHAR_SPACE) || (req_tdata == CHAR_TAB) ||
                       (req_tdata == CHAR_NL);

   always_comb begin
      line_in   = line_ff;
      word_in   = word_ff;
      byte_in   = byte_ff;
      inword_in = inword_ff;
      push_out.push          = 1'b0;
      push_out.snap.line_cnt = line_ff;
      push_out.snap.word_cnt = word_ff;
      push_out.snap.byte_cnt = byte_ff;
      if (accept) begin
         if (req_tuser[0] == CMD_END) begin
            // hand the totals over and start a fresh stream
            push_out.push = 1'b1;
            line_in   = '0;
            word_in   = '0;
            byte_in   = '0;
            inword_in = 1'b0;
         end else begin
            byte_in = byte_ff + 1'b1;
            if (req_tdata == CHAR_NL) begin
               line_in = line_ff + 1'b1;
            end
            if (blank) begin
               inword_in = 1'b0;
            end else if (!inword_ff) begin
               inword_in = 1'b1;
               word_in   = word_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff   <= '0;
         word_ff   <= '0;
         byte_ff   <= '0;
         inword_ff <= 1'b0;
      end else begin
         line_ff   <= line_in;
         word_ff   <= word_in;
         byte_ff   <= byte_in;
         inword_ff <= inword_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/wcr_queue.sv @@
// short queue of count snapshots between the front end and the report formatter
`default_nettype none
module wcr_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire wcr_pkg::wcr_push_type push_in,
   input  wire logic                 pop,
   output wcr_pkg::wcr_snap_type     snap_out,
   output logic                      empty,
   output logic                      full
);
   import wcr_pkg::*;

   wcr_snap_type      mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;

   assign empty    = (cnt_ff == '0);
   assign full     = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign snap_out = mem_ff[rd_ptr_ff];

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      logic [QPTR_W-1:0] r;
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   always_comb begin
      wr_ptr_in = push_in.push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_in.push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push_in.push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push_in.push) begin
         mem_ff[wr_ptr_ff] <= push_in.snap;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/wcr_back.sv @@
// back end: converts each count to decimal and streams the report characters
`default_nettype none
module wcr_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire wcr_pkg::wcr_snap_type q_snap,
   input  wire logic                 q_empty,
   output logic                      q_pop,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [7:0]                rsp_tdata,
   output logic                      rsp_tlast
);
   import wcr_pkg::*;

   localparam logic [1:0] FLD_LINE = 2'd0;
   localparam logic [1:0] FLD_WORD = 2'd1;
   localparam logic [1:0] FLD_BYTE = 2'd2;

   bk_state_type           state_ff, state_in;
   wcr_snap_type           snap_ff, snap_in;
   logic [1:0]             field_ff, field_in;
   logic [COUNT_WIDTH-1:0] bin_ff, bin_in;
   logic [BCD_WIDTH-1:0]   bcd_ff, bcd_in;
   logic [BIT_W-1:0]       bit_ff, bit_in;
   logic [DIG_W-1:0]       dig_ff, dig_in;
   logic                   started_ff, started_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_data_ff, rsp_data_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   out_free;
   logic [BCD_WIDTH-1:0]   adj;
   logic [3:0]             cur_digit;
   logic                   show;
   logic                   emit;
   logic [7:0]             emit_char;
   logic                   emit_last;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign cur_digit  = bcd_ff[{dig_ff, 2'b00} +: 4];
   assign show       = started_ff || (cur_digit != 4'd0) || (dig_ff == '0);

   function automatic logic [COUNT_WIDTH-1:0] pick(input wcr_snap_type s,
                                                   input logic [1:0] f);
      logic [COUNT_WIDTH-1:0] v;
      case (f)
         FLD_LINE: v = s.line_cnt;
         FLD_WORD: v = s.word_cnt;
         default:  v = s.byte_cnt;
      endcase
      return v;
   endfunction

   // add-3 correction per digit ahead of the shift
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      snap_in    = snap_ff;
      field_in   = field_ff;
      bin_in     = bin_ff;
      bcd_in     = bcd_ff;
      bit_in     = bit_ff;
      dig_in     = dig_ff;
      started_in = started_ff;
      q_pop      = 1'b0;
      emit       = 1'b0;
      emit_char  = CHAR_SPACE;
      emit_last  = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               snap_in  = q_snap;
               field_in = FLD_LINE;
               bin_in   = q_snap.line_cnt;
               bcd_in   = '0;
               bit_in   = BIT_W'(COUNT_WIDTH - 1);
               state_in = BK_CONV;
            end
         end
         BK_CONV: begin
            bcd_in = {adj[BCD_WIDTH-2:0], bin_ff[COUNT_WIDTH-1]};
            bin_in = {bin_ff[COUNT_WIDTH-2:0], 1'b0};
            bit_in = bit_ff - 1'b1;
            if (bit_ff == '0) begin
               state_in = BK_GAP1;
            end
         end
         BK_GAP1: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = BK_GAP2;
            end
         end
         BK_GAP2: begin
            if (out_free) begin
               emit       = 1'b1;
               dig_in     = DIG_W'(DIGITS - 1);
               started_in = 1'b0;
               state_in   = BK_DIGIT;
            end
         end
         BK_DIGIT: begin
            if (!show || out_free) begin
               if (show) begin
                  emit       = 1'b1;
                  emit_char  = CHAR_ZERO + {4'h0, cur_digit};
                  started_in = 1'b1;
               end
               dig_in = dig_ff - 1'b1;
               if (dig_ff == '0) begin
                  if (field_ff == FLD_BYTE) begin
                     state_in = BK_NL;
                  end else begin
                     field_in = field_ff + 1'b1;
                     bin_in   = pick(snap_ff, field_ff + 1'b1);
                     bcd_in   = '0;
                     bit_in   = BIT_W'(COUNT_WIDTH - 1);
                     state_in = BK_CONV;
                  end
               end
            end
         end
         BK_NL: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_char = CHAR_NL;
               emit_last = 1'b1;
               state_in  = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_char;
         rsp_last_in  = emit_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff     <= snap_in;
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      bit_ff      <= bit_in;
      dig_ff      <= dig_in;
      field_ff    <= field_in;
      started_ff  <= started_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/line_word_char_counter_report_core.sv @@
// top level of the line, word and byte counter with decimal text report
// request channel: one byte per request, req_tuser[0] set marks end of stream
// (the byte is then ignored); a data request is taken as soon as it is valid unless the queue is full
// response channel: the report text, one character per response, rsp_tlast
// on the closing newline: two spaces, lines, two spaces, words, two spaces,
// bytes, newline, each count in decimal without leading zeros
// an end-of-stream request copies the three counts into a two-entry queue and
// clears them in the same cycle, so the next stream can start at once
// the formatter takes one snapshot at a time; per count it runs the
// shift-and-add-3 binary to decimal converter over all COUNT_WIDTH bits,
// sends the two gap spaces, then steps through the decimal digit positions
// from the most significant, skipping leading zeros
// requests stall only while both queue entries hold reports not yet started
// a stalled receiver freezes the formatter at its next character; the
// registered output holds its character until taken
// reset (synchronous, active high) clears counts, queue and formatter
`default_nettype none
module line_word_char_counter_report_core (
   input  wire logic       clock,
   input  wire logic       reset,
   // request channel
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] data_byte
   input  wire logic [0:0] req_tuser,   // [0] cmd (0 data byte, 1 end of stream)
   // response channel
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_byte
   output logic            rsp_tlast    // last_out, closing newline of a report
);
   import wcr_pkg::*;

   wcr_push_type push;      // snapshot handed from front end to queue
   wcr_snap_type q_snap;    // oldest waiting snapshot
   logic         q_empty;
   logic         q_full;
   logic         q_pop;

   // counting front end
   wcr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .push_out   (push)
   );

   // snapshot queue decoupling counting from formatting
   wcr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_in  (push),
      .pop      (q_pop),
      .snap_out (q_snap),
      .empty    (q_empty),
      .full     (q_full)
   );

   // decimal conversion and report output
   wcr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_snap     (q_snap),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   // the front end never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.push |-> !q_full)
      else $error("snapshot pushed into full queue");

   // the formatter never pops an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("snapshot popped from empty queue");

   // the marked character of a report is always the newline
   a_last_is_newline: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata == CHAR_NL))
      else $error("report end marker on a character other than newline");

   // an end request with room in the queue leaves it non-empty next cycle
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      push.push |=> !q_empty)
      else $error("snapshot lost after push");
`endif

endmodule
`default_nettype wire

@@ verif/wcr_report_checker.sv @@
// checker for the line, word and byte counter: predicts each report and compares the responses
`timescale 1ns / 100ps
module wcr_report_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   input  wire logic       req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] data_byte
   input  wire logic [0:0] req_tuser,   // [0] cmd
   input  wire logic       rsp_tvalid,
   input  wire logic       rsp_tready,
   input  wire logic [7:0] rsp_tdata,   // [7:0] out_byte
   input  wire logic       rsp_tlast,
   output int              failures,
   output int              outstanding
);
   import wcr_pkg::*;

   typedef struct {
      logic [7:0] ch;
      logic       last;
   } report_char_type;

   report_char_type        report_chars[$];
   logic [COUNT_WIDTH-1:0] lines_seen;
   logic [COUNT_WIDTH-1:0] words_seen;
   logic [COUNT_WIDTH-1:0] bytes_seen;
   logic                   in_word;

   task automatic push_char(input logic [7:0] ch, input logic last);
      report_char_type rc;
      rc.ch   = ch;
      rc.last = last;
      report_chars.push_back(rc);
   endtask

   task automatic push_decimal(input logic [COUNT_WIDTH-1:0] value);
      logic [7:0]             digit_buf [0:19];
      logic [COUNT_WIDTH-1:0] rest;
      int                     n;
      rest = value;
      n    = 0;
      if (rest == '0) begin
         push_char(CHAR_ZERO, 1'b0);
      end else begin
         while (rest != '0) begin
            digit_buf[n] = CHAR_ZERO + 8'(rest % 10);
            n++;
            rest = rest / 10;
         end
         for (int i = n - 1; i >= 0; i--) push_char(digit_buf[i], 1'b0);
      end
   endtask

   task automatic count_text_byte(input logic [7:0] b);
      bytes_seen = bytes_seen + 1'b1;
      if (b == CHAR_NL) lines_seen = lines_seen + 1'b1;
      if (b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_NL) begin
         in_word = 1'b0;
      end else if (!in_word) begin
         in_word    = 1'b1;
         words_seen = words_seen + 1'b1;
      end
   endtask

   task automatic queue_report();
      push_char(CHAR_SPACE, 1'b0);
      push_char(CHAR_SPACE, 1'b0);
      push_decimal(lines_seen);
      push_char(CHAR_SPACE, 1'b0);
      push_char(CHAR_SPACE, 1'b0);
      push_decimal(words_seen);
      push_char(CHAR_SPACE, 1'b0);
      push_char(CHAR_SPACE, 1'b0);
      push_decimal(bytes_seen);
      push_char(CHAR_NL, 1'b1);
      lines_seen = '0;
      words_seen = '0;
      bytes_seen = '0;
      in_word    = 1'b0;
   endtask

   initial begin
      failures    = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      report_char_type want;
      if (reset) begin
         report_chars.delete();
         lines_seen = '0;
         words_seen = '0;
         bytes_seen = '0;
         in_word    = 1'b0;
      end else begin
         // responses first: a report never leaves in the cycle its request is taken
         if (rsp_tvalid && rsp_tready) begin
            if (report_chars.size() == 0) begin
               failures++;
               $display("%0t: unexpected response, expected none actual char %h last %b",
                        $time, rsp_tdata, rsp_tlast);
            end else begin
               want = report_chars.pop_front();
               if (rsp_tdata !== want.ch) begin
                  failures++;
                  $display("%0t: report char mismatch, expected %h actual %h",
                           $time, want.ch, rsp_tdata);
               end
               if (rsp_tlast !== want.last) begin
                  failures++;
                  $display("%0t: last flag mismatch, expected %b actual %b",
                           $time, want.last, rsp_tlast);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser[0] == CMD_END) queue_report();
            else count_text_byte(req_tdata);
         end
      end
      outstanding = report_chars.size();
   end

endmodule

@@ verif/line_word_char_counter_report_core_tb.sv @@
// testbench top for the line, word and byte counter: drives text streams and gives the verdict
`timescale 1ns / 100ps
module line_word_char_counter_report_core_tb;
   import wcr_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_WAIT  = 400;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic [0:0] req_tuser  = CMD_DATA;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;

   int failures;
   int outstanding;
   int send_idle   = 30;
   int recv_idle   = 52;
   int items_sent  = 0;
   int cycle_count = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   line_word_char_counter_report_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   wcr_report_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .failures    (failures),
      .outstanding (outstanding)
   );

   // receiver back-pressure, one decision per cycle
   always @(posedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // optional idle gap, then hold the request until it is taken
   task automatic send_request(input logic cmd, input logic [7:0] b);
      if ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom);
         @(posedge clock);
         while ($urandom_range(99) < send_idle) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // mostly letters and separators, now and then any byte at all
   function automatic logic [7:0] pick_text_byte();
      int r;
      r = $urandom_range(99);
      if (r < 50) return 8'h61 + 8'($urandom_range(25));
      if (r < 70) return CHAR_SPACE;
      if (r < 80) return CHAR_NL;
      if (r < 87) return CHAR_TAB;
      return 8'($urandom_range(255));
   endfunction

   // text length kept within the requests left in the phase
   task automatic send_document(input int room);
      int len;
      if ($urandom_range(7) == 0) len = $urandom_range(150, 60);
      else len = $urandom_range(20);
      if (len > room - 1) len = room - 1;
      if (len < 0) len = 0;
      for (int i = 0; i < len; i++) send_request(CMD_DATA, pick_text_byte());
      send_request(CMD_END, 8'($urandom_range(255)));
   endtask

   initial begin
      int goal;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty report, word at stream start, separators, odd bytes
      send_request(CMD_END, 8'h00);
      send_request(CMD_DATA, 8'h41);
      send_request(CMD_DATA, CHAR_SPACE);
      send_request(CMD_DATA, 8'hFF);
      send_request(CMD_DATA, CHAR_TAB);
      send_request(CMD_DATA, 8'h00);
      send_request(CMD_DATA, CHAR_NL);
      send_request(CMD_DATA, CHAR_NL);
      send_request(CMD_DATA, 8'h0B);
      send_request(CMD_DATA, 8'h0D);
      send_request(CMD_DATA, CHAR_SPACE);
      send_request(CMD_END, 8'hFF);
      // counts must have cleared; data byte on end ignored
      send_request(CMD_END, 8'hA5);
      send_request(CMD_DATA, CHAR_TAB);
      send_request(CMD_DATA, 8'h7F);
      send_request(CMD_DATA, 8'h80);
      send_request(CMD_END, 8'h5A);
      send_request(CMD_END, 8'h0A);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle = 30; recv_idle = 52; end
            1: begin send_idle = 52; recv_idle = 30; end
            default: begin send_idle = 0; recv_idle = 0; end
         endcase
         goal = items_sent + 67;
         while (items_sent < goal) send_document(goal - items_sent);
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
